// File: rtl/core/gsp_pkg.sv
`timescale 1ns / 1ps
// gsp_pkg: shared types and constants of the greedy subset packer
// no dependencies; used by the top, gsp_ctrl, gsp_dp and the bench

package gsp_pkg;

	localparam int MASK_W       = 16;
	localparam int SLOT_W       = 9;
	localparam int N_W          = 5;
	localparam int K_W          = 3;
	localparam int CFG_DATA_W   = 5;
	localparam int CFG_IDX_W    = 2;
	localparam int MAX_ELEMENTS = 16;
	localparam int N_CAP        = (MAX_ELEMENTS < MASK_W) ? MAX_ELEMENTS : MASK_W;
	localparam int K_LOW        = 3;
	localparam int K_HIGH       = 5;
	localparam int N_RESET      = 16;
	localparam int K_RESET      = 3;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_SET_SIZE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SUBSET_SIZE = 2'd1;

	typedef struct packed {
		logic restart;
	} adv_t;

	typedef struct packed {
		logic [MASK_W-1:0] candidate_mask;
		logic              kept;
		logic [SLOT_W-1:0] slot;
		logic              final_candidate;
		logic              overflow;
		logic              finished;
	} res_t;

	typedef enum logic [1:0] {
		RES_CLEAR,
		RES_FINISHED,
		RES_CAND
	} res_kind_t;

	// controller to datapath
	typedef struct packed {
		logic      restart;
		logic      scan_init;
		logic      scan_step;
		logic      load;
		res_kind_t kind;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic done;
		logic count_zero;
		logic last_issue;
		logic out_busy;
	} status_t;

endpackage

// File: rtl/core/gsp_stream_if.sv
`timescale 1ns / 1ps
// gsp_stream_if: valid/ready channel carrying one payload beat
// payload type is given at instantiation

interface gsp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/greedy_subset_packing_generator_top.sv
`timescale 1ns / 1ps
// greedy_subset_packing_generator_top: top level of the greedy subset packer
// depends on gsp_pkg, gsp_stream_if, gsp_ram, gsp_ctrl and gsp_dp
//
// usage
// - advance channel: one beat per request; restart = 1 restarts the enumeration
//   and empties the table, restart = 0 asks for the next k-subset of 0..n-1
// - result channel: exactly one beat per advance beat, in order: candidate mask,
//   kept flag, table slot, last-subset flag, table overflow, finished flag
// - config port: cfg_wr_en with cfg_index 0 (set size n) or 1 (subset size k);
//   any write to either register restarts the enumeration; write only while idle
// - scan: a candidate is checked against every kept mask, one table entry per
//   cycle through the table ram read port, then passes drain and emit in turn;
//   restart and finished beats, and candidates while the table is empty, go from
//   idle straight to emit; emit waits while the result register holds an untaken beat
// - one beat in flight: advance.ready is high only while the controller is idle
// - the result register holds a beat until taken; the next advance beat is
//   accepted and worked on meanwhile, and waits only to load its result
// - reset: n = 16, k = 3, table empty, first candidate is elements 0, 1, 2;
//   the table ram needs no clearing since only filled entries are ever read

module greedy_subset_packing_generator_top #(
	parameter int TABLE_DEPTH = 512
) (
	input  logic                            clk,
	input  logic                            arst_n,
	gsp_stream_if.sink                      advance,
	gsp_stream_if.source                    result,
	input  logic                            cfg_wr_en,
	input  logic [gsp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gsp_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// command and status between controller and datapath
	gsp_pkg::cmd_t    cmd;
	gsp_pkg::status_t status;

	// controller owns the advance channel and sequences the table scan
	gsp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.status  (status),
		.cmd     (cmd)
	);

	// datapath holds config, enumeration state, the table and the result register
	gsp_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

endmodule

// File: rtl/core/gsp_ram.sv
`timescale 1ns / 1ps
// gsp_ram: generic single write port, single read port ram with registered read
// no dependencies

module gsp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/core/gsp_ctrl.sv
`timescale 1ns / 1ps
// gsp_ctrl: controller state machine of the subset packer
// depends on gsp_pkg and gsp_stream_if

module gsp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	gsp_stream_if.sink        advance,
	input  gsp_pkg::status_t  status,
	output gsp_pkg::cmd_t     cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t              state_q;
	gsp_pkg::res_kind_t  kind_q;
	logic                accept;

	assign advance.ready = (state_q == ST_IDLE);
	assign accept        = advance.valid && advance.ready;

	always_comb begin
		cmd = '0;
		cmd.kind = kind_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.restart   = advance.data.restart;
					cmd.scan_init = !advance.data.restart && !status.done;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_EMIT: begin
				cmd.load = !status.out_busy;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= gsp_pkg::RES_CLEAR;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (advance.data.restart) begin
							kind_q  <= gsp_pkg::RES_CLEAR;
							state_q <= ST_EMIT;
						end else if (status.done) begin
							kind_q  <= gsp_pkg::RES_FINISHED;
							state_q <= ST_EMIT;
						end else if (status.count_zero) begin
							kind_q  <= gsp_pkg::RES_CAND;
							state_q <= ST_EMIT;
						end else begin
							kind_q  <= gsp_pkg::RES_CAND;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (status.last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!status.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/gsp_dp.sv
`timescale 1ns / 1ps
// gsp_dp: datapath of the subset packer: config, enumeration, table scan, result register
// depends on gsp_pkg, gsp_stream_if and gsp_ram

module gsp_dp #(
	parameter int TABLE_DEPTH = 512
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [gsp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gsp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  gsp_pkg::cmd_t                    cmd,
	output gsp_pkg::status_t                 status,
	gsp_stream_if.source                     result
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	function automatic logic [gsp_pkg::N_W-1:0] sat_n(input logic [gsp_pkg::N_W-1:0] n);
		sat_n = (n > gsp_pkg::N_W'(gsp_pkg::N_CAP)) ? gsp_pkg::N_W'(gsp_pkg::N_CAP) : n;
	endfunction

	function automatic logic [gsp_pkg::K_W-1:0] sat_k(input logic [gsp_pkg::K_W-1:0] k);
		if (k < gsp_pkg::K_W'(gsp_pkg::K_LOW)) begin
			sat_k = gsp_pkg::K_W'(gsp_pkg::K_LOW);
		end else if (k > gsp_pkg::K_W'(gsp_pkg::K_HIGH)) begin
			sat_k = gsp_pkg::K_W'(gsp_pkg::K_HIGH);
		end else begin
			sat_k = k;
		end
	endfunction

	function automatic logic [4:0] popcount(input logic [gsp_pkg::MASK_W-1:0] x);
		logic [4:0] c;
		c = '0;
		for (int b = 0; b < gsp_pkg::MASK_W; b++) begin
			c = c + 5'(x[b]);
		end
		popcount = c;
	endfunction

	logic [gsp_pkg::N_W-1:0]    n_q, n_nx, eff_n, eff_n_nx;
	logic [gsp_pkg::K_W-1:0]    k_q, k_nx, eff_k, eff_k_nx;
	logic [gsp_pkg::MASK_W-1:0] cur_q, nxt_mask, hm;
	logic [CW-1:0]              count_q, idx_q;
	logic                       done_q, fail_q, chk_s1, out_valid_q;
	gsp_pkg::res_t              out_q, out_d;
	logic                       cfg_hit, do_restart, full, pass, hit, commit;
	logic [gsp_pkg::MASK_W-1:0] rd_data;
	logic [3:0]                 q_pos, p_pos;
	logic                       q_found, p_found, last;
	logic [4:0]                 run_len;
	logic [CW+gsp_pkg::SLOT_W-1:0] slot_ext;

	// config write decode; any valid write restarts the enumeration
	always_comb begin
		cfg_hit = 1'b0;
		n_nx    = n_q;
		k_nx    = k_q;
		if (cfg_wr_en) begin
			unique case (cfg_index)
				gsp_pkg::CFG_SET_SIZE: begin
					cfg_hit = 1'b1;
					n_nx    = cfg_data;
				end
				gsp_pkg::CFG_SUBSET_SIZE: begin
					cfg_hit = 1'b1;
					k_nx    = cfg_data[gsp_pkg::K_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign eff_n      = sat_n(n_q);
	assign eff_k      = sat_k(k_q);
	assign eff_n_nx   = sat_n(n_nx);
	assign eff_k_nx   = sat_k(k_nx);
	assign do_restart = cfg_hit || cmd.restart;

	// next subset in lexicographic order: the run of set bits ending at n-1 moves down
	// to sit just above the highest set bit below it, which itself steps up by one
	always_comb begin
		q_found = 1'b0;
		q_pos   = '0;
		p_found = 1'b0;
		p_pos   = '0;
		for (int b = 0; b < gsp_pkg::MASK_W; b++) begin
			hm[b] = cur_q[b] || !(5'(b) < eff_n);
		end
		for (int b = 0; b < gsp_pkg::MASK_W; b++) begin
			if (!hm[b]) begin
				q_found = 1'b1;
				q_pos   = 4'(b);
			end
		end
		run_len = eff_n - {1'b0, q_pos} - 5'd1;
		for (int b = 0; b < gsp_pkg::MASK_W; b++) begin
			if (cur_q[b] && q_found && (4'(b) < q_pos)) begin
				p_found = 1'b1;
				p_pos   = 4'(b);
			end
		end
		last = !p_found;
		for (int b = 0; b < gsp_pkg::MASK_W; b++) begin
			if (4'(b) < p_pos) begin
				nxt_mask[b] = cur_q[b];
			end else begin
				nxt_mask[b] = (5'(b) > {1'b0, p_pos})
					&& (6'(b) <= (6'(p_pos) + 6'(run_len) + 6'd1));
			end
		end
	end

	assign full     = (count_q == CW'(TABLE_DEPTH));
	assign pass     = !fail_q;
	assign hit      = popcount(cur_q & rd_data) >= (5'(eff_k) - 5'd1);
	assign commit   = cmd.load && (cmd.kind == gsp_pkg::RES_CAND);
	assign slot_ext = {{gsp_pkg::SLOT_W{1'b0}}, count_q};

	gsp_ram #(
		.WIDTH (gsp_pkg::MASK_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (commit && pass && !full),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (cur_q),
		.rd_en   (cmd.scan_step),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= gsp_pkg::N_W'(gsp_pkg::N_RESET);
			k_q     <= gsp_pkg::K_W'(gsp_pkg::K_RESET);
			cur_q   <= (gsp_pkg::MASK_W'(1) << gsp_pkg::K_RESET) - gsp_pkg::MASK_W'(1);
			count_q <= '0;
			done_q  <= (gsp_pkg::K_RESET > sat_n(gsp_pkg::N_W'(gsp_pkg::N_RESET)));
			idx_q   <= '0;
			fail_q  <= 1'b0;
			chk_s1  <= 1'b0;
		end else begin
			n_q    <= n_nx;
			k_q    <= k_nx;
			chk_s1 <= cmd.scan_step;
			if (cmd.scan_init) begin
				idx_q  <= '0;
				fail_q <= 1'b0;
			end else begin
				if (cmd.scan_step) begin
					idx_q <= idx_q + CW'(1);
				end
				if (chk_s1 && hit) begin
					fail_q <= 1'b1;
				end
			end
			if (do_restart) begin
				cur_q   <= (gsp_pkg::MASK_W'(1) << eff_k_nx) - gsp_pkg::MASK_W'(1);
				count_q <= '0;
				done_q  <= (5'(eff_k_nx) > eff_n_nx);
			end else if (commit) begin
				if (pass && !full) begin
					count_q <= count_q + CW'(1);
				end
				if (last) begin
					done_q <= 1'b1;
				end else begin
					cur_q <= nxt_mask;
				end
			end
		end
	end

	// result register: takes a new beat when empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result beat contents for the kind being loaded
	always_comb begin
		out_d = '0;
		case (cmd.kind)
			gsp_pkg::RES_FINISHED: begin
				out_d.finished = 1'b1;
			end
			gsp_pkg::RES_CAND: begin
				out_d.candidate_mask  = cur_q;
				out_d.kept            = pass && !full;
				out_d.slot            = (pass && !full) ? slot_ext[gsp_pkg::SLOT_W-1:0] : '0;
				out_d.overflow        = pass && full;
				out_d.final_candidate = last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q <= out_d;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	assign status.done       = done_q;
	assign status.count_zero = (count_q == '0);
	assign status.last_issue = ((idx_q + CW'(1)) == count_q);
	assign status.out_busy   = out_valid_q && !result.ready;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for greedy_subset_packing_generator_top
// depends on gsp_pkg, gsp_stream_if and the block's rtl; holds its own lexicode predictor

module tb_top;
	import gsp_pkg::*;

	// table depth of the block as delivered
	localparam int TABLE_DEPTH = 512;
	// index 2 and 3 are not registers; a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
	localparam int TARGET_BEATS = 850;

	// scoreboard: lexicographic k-subset walk with a greedy distance-4 packing table
	class lexicode_scoreboard;
		logic [N_W-1:0]    set_size_reg;
		logic [K_W-1:0]    subset_size_reg;
		logic [MASK_W-1:0] next_mask;
		logic [MASK_W-1:0] kept_masks[$];
		bit                enum_over;
		bit                overflow_seen;
		res_t              expected_beats[$];
		int                mismatches;

		function new();
			set_size_reg = N_W'(N_RESET);
			subset_size_reg = K_W'(K_RESET);
			mismatches = 0;
			overflow_seen = 0;
			restart_enum();
		endfunction

		function int eff_n();
			return (set_size_reg > N_CAP) ? N_CAP : int'(set_size_reg);
		endfunction

		function int eff_k();
			if (subset_size_reg < K_LOW)
				return K_LOW;
			if (subset_size_reg > K_HIGH)
				return K_HIGH;
			return int'(subset_size_reg);
		endfunction

		function void restart_enum();
			next_mask = MASK_W'((1 << eff_k()) - 1);
			kept_masks.delete();
			enum_over = eff_k() > eff_n();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_SET_SIZE: set_size_reg = val[N_W-1:0];
				CFG_SUBSET_SIZE: subset_size_reg = val[K_W-1:0];
				default: return;
			endcase
			restart_enum();
		endfunction

		// next k-subset in lexicographic order of sorted element lists
		function bit lex_successor(input logic [MASK_W-1:0] cur, output logic [MASK_W-1:0] nxt);
			int pos[K_HIGH];
			int cnt;
			int n;
			int k;
			int j;
			int b;
			n = eff_n();
			k = eff_k();
			cnt = 0;
			nxt = '0;
			for (b = 0; b < MASK_W; b++) begin
				if (cur[b] && cnt < K_HIGH) begin
					pos[cnt] = b;
					cnt++;
				end
			end
			if (cnt != k)
				return 0;
			for (j = k - 1; j >= 0; j--) begin
				if (pos[j] < n - k + j) begin
					pos[j]++;
					for (b = j + 1; b < k; b++)
						pos[b] = pos[b-1] + 1;
					for (b = 0; b < k; b++)
						nxt[pos[b]] = 1'b1;
					return 1;
				end
			end
			return 0;
		endfunction

		function void note_advance(adv_t beat);
			res_t r;
			logic [MASK_W-1:0] nxt;
			bit clash;
			r = '0;
			if (beat.restart) begin
				restart_enum();
			end else if (enum_over) begin
				r.finished = 1'b1;
			end else begin
				r.candidate_mask = next_mask;
				clash = 0;
				foreach (kept_masks[i])
					if ($countones(next_mask & kept_masks[i]) >= eff_k() - 1)
						clash = 1;
				if (!clash) begin
					if (kept_masks.size() < TABLE_DEPTH) begin
						r.kept = 1'b1;
						r.slot = SLOT_W'(kept_masks.size());
						kept_masks = {kept_masks, next_mask};
					end else begin
						r.overflow = 1'b1;
						overflow_seen = 1;
					end
				end
				if (lex_successor(next_mask, nxt)) begin
					next_mask = nxt;
				end else begin
					r.final_candidate = 1'b1;
					enum_over = 1;
				end
			end
			expected_beats = {expected_beats, r};
		endfunction

		function void field_check(string name, logic [MASK_W-1:0] want, logic [MASK_W-1:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_beats.size() == 0) begin
				$error("result beat with nothing expected: %p", got);
				mismatches++;
				return;
			end
			want = expected_beats.pop_front();
			field_check("candidate_mask", want.candidate_mask, got.candidate_mask);
			field_check("kept", MASK_W'(want.kept), MASK_W'(got.kept));
			field_check("slot", MASK_W'(want.slot), MASK_W'(got.slot));
			field_check("final_candidate", MASK_W'(want.final_candidate),
				MASK_W'(got.final_candidate));
			field_check("overflow", MASK_W'(want.overflow), MASK_W'(got.overflow));
			field_check("finished", MASK_W'(want.finished), MASK_W'(got.finished));
		endfunction

		function bit busy();
			return expected_beats.size() != 0;
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	gsp_stream_if #(.payload_t(adv_t)) advance_ch ();
	gsp_stream_if #(.payload_t(res_t)) result_ch ();

	lexicode_scoreboard lexicode;
	int                 beats_sent = 0;
	bit                 steady = 0;

	// receiver stall pattern, rotated every cycle and swapped now and then
	logic [15:0] stall_pattern = 16'hFFFF;
	int          stall_ticks = 0;

	greedy_subset_packing_generator_top #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance_ch),
		.result(result_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// result side: every accepted beat is checked against the oldest expectation
	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready)
			lexicode.check_result(result_ch.data);
	end

	// receiver: free-flowing stretches, sparse acceptance and long stalls in turn
	always @(posedge clk) begin
		if (stall_ticks == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pattern = 16'hFFFF;
				1: stall_pattern = 16'($urandom) | 16'h0001;
				2: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
				default: stall_pattern = 16'hF000;
			endcase
			stall_ticks = $urandom_range(50, 300);
		end else begin
			stall_ticks--;
		end
		stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
		result_ch.ready <= stall_pattern[0];
	end

	// one advance beat; returns at the edge where it is taken, valid left high
	task automatic send_advance(input logic rs);
		adv_t beat;
		beat.restart = rs;
		advance_ch.valid <= 1'b1;
		advance_ch.data <= beat;
		@(posedge clk);
		while (!advance_ch.ready)
			@(posedge clk);
		lexicode.note_advance(beat);
		beats_sent++;
	endtask

	// sender pauses until the block has answered every beat it took
	task automatic drain();
		advance_ch.valid <= 1'b0;
		while (lexicode.busy())
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	// register write, only ever issued after drain()
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		lexicode.write_reg(idx, val);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// bursty run of advance beats with the odd restart mixed in
	task automatic run_advances(input int beats, input int restart_pct, input bit until_overflow);
		int burst;
		int gap;
		int i;
		steady = ($urandom_range(0, 3) == 0);
		burst = $urandom_range(1, 12);
		for (i = 0; i < beats; i++) begin
			if (until_overflow && lexicode.overflow_seen)
				break;
			send_advance($urandom_range(0, 99) < restart_pct);
			burst--;
			if (burst == 0) begin
				burst = $urandom_range(1, 12);
				gap = steady ? 0 : $urandom_range(0, 6);
				if (gap > 0) begin
					advance_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] n_val;
		logic [CFG_DATA_W-1:0] k_val;
		lexicode = new();
		advance_ch.valid = 1'b0;
		advance_ch.data = '0;
		result_ch.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_SET_SIZE;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting n = 16, k = 3: first kept, then two rejected neighbors
		send_advance(1'b0);
		send_advance(1'b0);
		send_advance(1'b0);
		// restart beat gives all-zero result, then the walk starts over
		send_advance(1'b1);
		send_advance(1'b0);
		drain();

		// n = k = 3: a single subset, then a finished answer, restart, again
		write_reg(CFG_SET_SIZE, 5'd3);
		send_advance(1'b0);
		send_advance(1'b0);
		send_advance(1'b1);
		send_advance(1'b0);
		drain();

		// k written with upper data bits set (k = 4 > n): over at once
		write_reg(CFG_SUBSET_SIZE, 5'd28);
		send_advance(1'b0);
		drain();

		// n = 0, then n and k beyond their ranges saturate to 16 and 5
		write_reg(CFG_SET_SIZE, 5'd0);
		send_advance(1'b0);
		drain();
		write_reg(CFG_SET_SIZE, 5'd31);
		write_reg(CFG_SUBSET_SIZE, 5'd7);
		send_advance(1'b0);
		send_advance(1'b0);
		drain();

		// n = k = 5: the only subset is also the last
		write_reg(CFG_SET_SIZE, 5'd5);
		write_reg(CFG_SUBSET_SIZE, 5'd5);
		send_advance(1'b0);
		drain();

		// k = 0 saturates up to 3; a write to an unused index must not restart
		write_reg(CFG_SET_SIZE, 5'd4);
		write_reg(CFG_SUBSET_SIZE, 5'd0);
		send_advance(1'b0);
		send_advance(1'b0);
		drain();
		write_reg(CFG_UNUSED_IDX, 5'h1F);
		send_advance(1'b0);
		send_advance(1'b0);
		send_advance(1'b0);
		drain();

		// long walk at n = 16, k = 3 with the table growing
		write_reg(CFG_SET_SIZE, 5'd16);
		write_reg(CFG_SUBSET_SIZE, 5'd3);
		run_advances(400, 0, 1'b0);
		run_advances(6, 0, 1'b0);
		drain();

		// random phases: mostly small sets that run to the end, some large ones
		while (beats_sent < TARGET_BEATS) begin
			drain();
			if ($urandom_range(0, 3) != 0) begin
				n_val = CFG_DATA_W'(($urandom_range(0, 9) < 7) ? $urandom_range(3, 9)
					: $urandom_range(10, 16));
				if ($urandom_range(0, 9) == 0)
					n_val = CFG_DATA_W'($urandom_range(0, 31));
				k_val = CFG_DATA_W'($urandom_range(3, 5));
				if ($urandom_range(0, 6) == 0)
					k_val = CFG_DATA_W'($urandom_range(0, 31));
				case ($urandom_range(0, 3))
					0: write_reg(CFG_SET_SIZE, n_val);
					1: write_reg(CFG_SUBSET_SIZE, k_val);
					2: begin
						write_reg(CFG_SUBSET_SIZE, k_val);
						write_reg(CFG_SET_SIZE, n_val);
					end
					default: begin
						write_reg(CFG_SET_SIZE, n_val);
						write_reg(CFG_SUBSET_SIZE, k_val);
					end
				endcase
			end
			run_advances($urandom_range(8, 100), $urandom_range(0, 5), 1'b0);
		end

		drain();
		repeat (20) @(posedge clk);
		if (lexicode.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#20000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
